### sv/abkf_pkg.sv
// Package for the angle/bias Kalman filter: payload structs, sequencer states,
// register indexes, reset values and fixed-point helpers. No dependencies.
package abkf_pkg;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] gyro_rate;
        logic signed [31:0] observed_angle;
    } t_in;

    typedef struct packed {
        logic [1:0]         axis_out;
        logic signed [31:0] filtered_angle;
        logic signed [31:0] corrected_rate;
    } t_out;

    typedef struct packed {
        logic signed [31:0] ang;
        logic signed [31:0] bias;
        logic signed [31:0] p00;
        logic signed [31:0] p01;
        logic signed [31:0] p10;
        logic signed [31:0] p11;
    } t_axis_state;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_LOAD, S_M_RB, S_ANG, S_M_P11, S_T, S_M_P10, S_M_T,
        S_P00, S_DIV0, S_DIV1, S_Y, S_M_K0Y, S_M_K1Y, S_M_K0P00, S_M_K0P01,
        S_M_K1P00, S_M_K1P01, S_P11, S_WRITE, S_OUT
    } t_state;

    localparam logic [1:0] REG_DT = 2'd0;
    localparam logic [1:0] REG_QA = 2'd1;
    localparam logic [1:0] REG_QB = 2'd2;
    localparam logic [1:0] REG_R  = 2'd3;

    localparam logic [31:0] DT_RST = 32'd4294967;
    localparam logic [31:0] QA_RST = 32'd21474836;
    localparam logic [31:0] QB_RST = 32'd21474836;
    localparam logic [31:0] R_RST  = 32'd128849019;
    localparam logic signed [31:0] BIAS_RST = 32'sd197;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Round to nearest, ties away from zero, shift by s.
    function automatic logic signed [65:0] rshr(input logic signed [65:0] p,
                                                 input int unsigned s);
        logic [65:0] m;
        logic        neg;
        neg = p[65];
        m = neg ? 66'(-p) : 66'(p);
        m = (m + (66'd1 << (s - 1))) >> s;
        return neg ? 66'(-$signed(m)) : $signed(m);
    endfunction

    function automatic logic signed [65:0] to_q16(input logic [31:0] v);
        return $signed(66'((34'(v) + 34'd32768) >> 16));
    endfunction

endpackage

### sv/abkf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module abkf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                             i_wdata,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### sv/angle_bias_kalman_filter.sv
// Angle/bias Kalman filter top level; uses abkf_pkg and abkf_ram.
// Each accepted beat returns one result beat; an in-range one updates that axis's state.
//
// For an in-range axis the input beat steps through the state RAM read, the
// predict and update steps, the write back and the output; the next input beat
// is taken once the sequencer is back in S_IDLE. The two bit-serial gain
// divisions each find 64 quotient bits and then take a finishing step, and the
// shared 32x33 multiplier needs one step per product.
// Out-of-range axis beats go straight to S_OUT and return zeros without
// touching the state. A result beat that waits on the output holds the next
// item in its last step until it is taken. After reset a clearing pass writes
// the reset state to each axis entry in turn; no input beat is taken until it
// ends. Config writes are always taken.
module angle_bias_kalman_filter #(
    parameter int AXES = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  abkf_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output abkf_pkg::t_out       o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import abkf_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int SW = $bits(t_axis_state);

    t_state r_state, n_state;
    logic [31:0] r_dt, r_qa, r_qb, r_r;
    logic [AW:0] r_clr;
    t_in r_in;
    t_axis_state r_st, ram_q, ram_d;
    logic ram_we;
    logic [AW-1:0] ram_a;
    logic signed [31:0] r_rb, r_p11dt, r_t, r_y, r_k0, r_k1, r_s31;
    logic signed [65:0] r_prod, r_acc;
    logic signed [31:0] mul_a;
    logic [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] r_s;
    // Divider state: magnitudes, remainder, quotient.
    logic [63:0] r_num;
    logic [33:0] r_den;
    logic [34:0] r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_cnt;
    logic        r_neg;
    t_out r_out;
    logic r_ovalid;
    logic r_clearing;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = (r_state == S_IDLE) && !r_clearing;
    assign o_out_valid = r_ovalid;
    assign o_out_data = r_out;
    assign mul_p = mul_a * $signed(mul_b);

    abkf_ram #(.WIDTH(SW), .DEPTH(AXES)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_a),
        .i_wdata(ram_d), .o_rdata(ram_q)
    );

    always_comb begin
        ram_we = 1'b0;
        ram_a = AW'(r_in.axis);
        ram_d = r_st;
        if (r_clearing) begin
            ram_we = 1'b1;
            ram_a = r_clr[AW-1:0];
            ram_d = '{ang: '0, bias: BIAS_RST, p00: '0, p01: '0, p10: '0, p11: '0};
        end else if (r_state == S_WRITE) begin
            ram_we = 1'b1;
        end
    end

    // Multiplier operand selection per step; dt operands are unsigned.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M_RB:    begin mul_a = r_rb;     mul_b = {1'b0, r_dt}; end
            S_M_P11:   begin mul_a = r_st.p11; mul_b = {1'b0, r_dt}; end
            S_M_P10:   begin mul_a = r_st.p10; mul_b = {1'b0, r_dt}; end
            S_M_T:     begin mul_a = r_t;      mul_b = {1'b0, r_dt}; end
            S_M_K0Y:   begin mul_a = r_k0; mul_b = 33'($signed(r_y)); end
            S_M_K1Y:   begin mul_a = r_k1; mul_b = 33'($signed(r_y)); end
            S_M_K0P00: begin mul_a = r_k0; mul_b = 33'($signed(r_st.p00)); end
            S_M_K0P01: begin mul_a = r_k0; mul_b = 33'($signed(r_st.p01)); end
            S_M_K1P00: begin mul_a = r_k1; mul_b = 33'($signed(r_st.p00)); end
            // The predicted P01 is still held in r_t; r_st.p01 is already shrunk.
            S_M_K1P01: begin mul_a = r_k1; mul_b = 33'($signed(r_t)); end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid && o_in_ready) begin
                           n_state = (32'(i_in_data.axis) >= AXES) ? S_OUT : S_READ;
                       end
            S_READ:    n_state = S_LOAD;
            S_LOAD:    n_state = S_M_RB;
            S_M_RB:    n_state = S_ANG;
            S_ANG:     n_state = S_M_P11;
            S_M_P11:   n_state = S_T;
            S_T:       n_state = S_M_P10;
            S_M_P10:   n_state = S_M_T;
            S_M_T:     n_state = S_P00;
            S_P00:     n_state = S_DIV0;
            S_DIV0:    if (r_cnt == 7'd64) n_state = S_DIV1;
            S_DIV1:    if (r_cnt == 7'd64) n_state = S_Y;
            S_Y:       n_state = S_M_K0Y;
            S_M_K0Y:   n_state = S_M_K1Y;
            S_M_K1Y:   n_state = S_M_K0P00;
            S_M_K0P00: n_state = S_M_K0P01;
            S_M_K0P01: n_state = S_M_K1P00;
            S_M_K1P00: n_state = S_M_K1P01;
            S_M_K1P01: n_state = S_P11;
            S_P11:     n_state = S_WRITE;
            S_WRITE:   n_state = S_OUT;
            S_OUT:     if (!r_ovalid || i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dt <= DT_RST; r_qa <= QA_RST; r_qb <= QB_RST; r_r <= R_RST;
            r_clr <= '0;
            r_clearing <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (32'(r_clr) == AXES - 1) r_clearing <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DT: r_dt <= i_cfg_data;
                    REG_QA: r_qa <= i_cfg_data;
                    REG_QB: r_qb <= i_cfg_data;
                    REG_R:  r_r  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: r_in <= i_in_data;
            S_LOAD: begin
                r_st <= ram_q;
                r_rb <= sat32(66'(r_in.gyro_rate) - 66'(ram_q.bias));
            end
            S_ANG: r_st.ang <= sat32(66'(r_st.ang) + rshr(r_prod, 32));
            S_T: begin
                r_p11dt <= sat32(rshr(r_prod, 32));
                r_t <= sat32(66'(r_st.p01) - rshr(r_prod, 32));
            end
            S_M_T: begin
                r_acc <= 66'(r_st.p00) - rshr(r_prod, 32);
                r_st.p10 <= sat32(66'(r_st.p10) - 66'(r_p11dt));
                r_st.p01 <= r_t;
                r_st.p11 <= sat32(66'(r_st.p11) + to_q16(r_qb));
            end
            S_P00: begin : p00_blk
                logic signed [31:0] p00n;
                logic signed [65:0] s;
                p00n = sat32(r_acc - rshr(r_prod, 32) + to_q16(r_qa));
                s = 66'(p00n) + to_q16(r_r);
                r_st.p00 <= p00n;
                r_s <= s;
                r_num <= 64'(p00n[31] ? -66'(p00n) : 66'(p00n)) << 30;
                r_neg <= p00n[31];
                r_den <= s[33:0];
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV0, S_DIV1: begin : div_blk
                logic [34:0] tr;
                logic signed [65:0] q;
                logic signed [31:0] kq;
                if (r_cnt != 7'd64) begin
                    tr = {r_rem[33:0], r_num[63]};
                    if (tr >= {1'b0, r_den}) begin
                        r_rem <= tr - {1'b0, r_den};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= tr;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_num <= {r_num[62:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                end else begin
                    q = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
                    kq = (r_s <= 0) ? 32'sd0 : sat32(q);
                    if (r_state == S_DIV0) begin
                        r_k0 <= kq;
                        r_num <= 64'(r_st.p10[31] ? -66'(r_st.p10) : 66'(r_st.p10)) << 30;
                        r_neg <= r_st.p10[31];
                        r_rem <= '0;
                        r_cnt <= '0;
                    end else begin
                        r_k1 <= kq;
                    end
                end
            end
            S_Y: r_y <= sat32(66'(r_in.observed_angle) - 66'(r_st.ang));
            S_M_K1Y: r_st.ang <= sat32(66'(r_st.ang) + rshr(r_prod, 30));
            S_M_K0P00: r_s31 <= sat32(66'(r_st.bias) + rshr(r_prod, 30));
            S_M_K0P01: r_acc <= 66'(r_st.p00) - rshr(r_prod, 30);
            S_M_K1P00: begin
                r_st.p00 <= sat32(r_acc);
                r_st.p01 <= sat32(66'(r_st.p01) - rshr(r_prod, 30));
                r_st.bias <= r_s31;
            end
            S_M_K1P01: r_st.p10 <= sat32(66'(r_st.p10) - rshr(r_prod, 30));
            S_P11: r_st.p11 <= sat32(66'(r_st.p11) - rshr(r_prod, 30));
            S_OUT: if (!r_ovalid || i_out_ready) begin
                r_out.axis_out <= r_in.axis;
                if (32'(r_in.axis) >= AXES) begin
                    r_out.filtered_angle <= '0;
                    r_out.corrected_rate <= '0;
                end else begin
                    r_out.filtered_angle <= r_st.ang;
                    r_out.corrected_rate <= sat32(66'(r_in.gyro_rate) - 66'(r_st.bias));
                end
            end
            default: ;
        endcase
    end
endmodule
